/* src/bzc_pkg.sv */
`default_nettype none
package bzc_pkg;

  localparam int unsigned MV_W     = 16;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [MV_W-1:0]     HYST_RESET    = 16'd50;
  localparam logic [MV_W-1:0]     BLANK_RESET   = 16'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_COUNT  = 3'd6;
  localparam logic [SECTOR_W-1:0] SECTOR_LAST   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_HYST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 2'd1;

  typedef enum logic [1:0] {
    PH_U    = 2'd0,
    PH_V    = 2'd1,
    PH_W    = 2'd2,
    PH_NONE = 2'd3
  } phase_t;

  typedef enum logic {
    ACT_ARM    = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    phase_t phase;
    logic   rising;
  } edge_t;

  typedef struct packed {
    logic [MV_W-1:0] hyst_mv;
    logic [MV_W-1:0] blank_us;
  } cfg_t;

  typedef struct packed {
    action_t              action;
    logic [SECTOR_W-1:0]  sector;
    logic                 reverse_dir;
    logic [TS_W-1:0]      timestamp_us;
    logic [MV_W-1:0]      bus_mid_mv;
    logic [MV_W-1:0]      float_mv;
  } item_t;

  typedef struct packed {
    logic   crossing_found;
    phase_t watched_phase;
    logic   watched_rising;
  } result_t;

  // forward commutation table, valid sectors only
  function automatic edge_t edge_lookup(input logic [SECTOR_W-1:0] idx);
    edge_t e;
    unique case (idx)
      3'd0:    e = '{phase: PH_W, rising: 1'b1};
      3'd1:    e = '{phase: PH_V, rising: 1'b0};
      3'd2:    e = '{phase: PH_U, rising: 1'b1};
      3'd3:    e = '{phase: PH_W, rising: 1'b0};
      3'd4:    e = '{phase: PH_V, rising: 1'b1};
      3'd5:    e = '{phase: PH_U, rising: 1'b0};
      default: e = '{phase: PH_NONE, rising: 1'b1};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

/* src/bemf_zero_cross_detector.sv */
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tuser: action; tdata: sector..float_mv
// out     | out | out_tvalid/tready  | tdata: crossing_found, phase, rising
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One request per cycle while out_tready is high; out_tvalid rises from the output register.
// Input register feeds one compare stage that updates detector state and the output register.
// Synchronous active-low reset; detector is inert until the first arm request.
// Output stall backs up through the input register; cfg_ready is always high.
`default_nettype none
module bemf_zero_cross_detector (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [2:0] sector, [3] reverse_dir, [35:4] timestamp_us, [51:36] bus_mid_mv,
  // [67:52] float_mv, [71:68] zero
  input  wire logic [bzc_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] action
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] crossing_found, [2:1] watched_phase, [3] watched_rising, [7:4] zero
  output logic [bzc_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bzc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bzc_pkg::MV_W-1:0]           cfg_data
);

  bzc_pkg::cfg_t     cfg;
  bzc_pkg::item_t    item_r, item_nxt;
  bzc_pkg::result_t  res;
  bzc_pkg::result_t  res_r, res_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              fire;
  logic              in_fire;

  bzc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_nxt.action       = bzc_pkg::action_t'(in_tuser);
    item_nxt.sector       = in_tdata[2:0];
    item_nxt.reverse_dir  = in_tdata[3];
    item_nxt.timestamp_us = in_tdata[35:4];
    item_nxt.bus_mid_mv   = in_tdata[51:36];
    item_nxt.float_mv     = in_tdata[67:52];
  end

  bzc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_tready);
  assign res_nxt       = fire ? res : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.watched_rising, res_r.watched_phase,
                       res_r.crossing_found};

endmodule
`default_nettype wire

/* src/bzc_cfg.sv */
`default_nettype none
module bzc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bzc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bzc_pkg::MV_W-1:0]       cfg_data,
  output bzc_pkg::cfg_t                       cfg_o
);

  logic [bzc_pkg::MV_W-1:0] hyst_r, hyst_nxt;
  logic [bzc_pkg::MV_W-1:0] blank_r, blank_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    hyst_nxt  = hyst_r;
    blank_nxt = blank_r;
    if (cfg_valid) begin
      if (cfg_index == bzc_pkg::CFG_HYST) begin
        hyst_nxt = cfg_data;
      end else if (cfg_index == bzc_pkg::CFG_BLANK) begin
        blank_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r  <= bzc_pkg::HYST_RESET;
      blank_r <= bzc_pkg::BLANK_RESET;
    end else begin
      hyst_r  <= hyst_nxt;
      blank_r <= blank_nxt;
    end
  end

  assign cfg_o.hyst_mv  = hyst_r;
  assign cfg_o.blank_us = blank_r;

endmodule
`default_nettype wire

/* src/bzc_core.sv */
`default_nettype none
module bzc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire bzc_pkg::item_t  item,
  input  wire bzc_pkg::cfg_t   cfg,
  output bzc_pkg::result_t     res
);

  bzc_pkg::phase_t             phase_r, phase_nxt;
  logic                        rising_r, rising_nxt;
  logic [bzc_pkg::TS_W-1:0]    blank_end_r, blank_end_nxt;
  logic                        pre_r, pre_nxt;
  logic                        done_r, done_nxt;

  bzc_pkg::edge_t              lut;
  logic [bzc_pkg::SECTOR_W-1:0] lut_idx;
  logic [bzc_pkg::MV_W:0]      phase_plus_h;
  logic [bzc_pkg::MV_W:0]      half_plus_h;
  logic                        below;
  logic                        above;
  logic                        pre_hit;
  logic                        post_hit;
  logic                        active;
  logic                        found;

  assign lut_idx = item.reverse_dir ? (bzc_pkg::SECTOR_LAST - item.sector) : item.sector;
  assign lut     = bzc_pkg::edge_lookup(lut_idx);

  assign phase_plus_h = {1'b0, item.float_mv} + {1'b0, cfg.hyst_mv};
  assign half_plus_h  = {1'b0, item.bus_mid_mv} + {1'b0, cfg.hyst_mv};
  assign below        = phase_plus_h < {1'b0, item.bus_mid_mv};
  assign above        = {1'b0, item.float_mv} > half_plus_h;
  assign pre_hit      = rising_r ? below : above;
  assign post_hit     = rising_r ? above : below;
  assign active       = !done_r && (item.timestamp_us > blank_end_r);

  always_comb begin
    phase_nxt     = phase_r;
    rising_nxt    = rising_r;
    blank_end_nxt = blank_end_r;
    pre_nxt       = pre_r;
    done_nxt      = done_r;
    found         = 1'b0;
    if (fire) begin
      unique case (item.action)
        bzc_pkg::ACT_ARM: begin
          if (item.sector >= bzc_pkg::SECTOR_COUNT) begin
            phase_nxt  = bzc_pkg::PH_NONE;
            rising_nxt = 1'b1;
          end else begin
            phase_nxt  = lut.phase;
            rising_nxt = lut.rising ^ item.reverse_dir;
          end
          blank_end_nxt = item.timestamp_us + {{(bzc_pkg::TS_W-bzc_pkg::MV_W){1'b0}},
                                               cfg.blank_us};
          pre_nxt  = 1'b0;
          done_nxt = 1'b0;
        end
        bzc_pkg::ACT_SAMPLE: begin
          if (active) begin
            if (pre_hit) begin
              pre_nxt = 1'b1;
            end
            if (pre_r && post_hit) begin
              done_nxt = 1'b1;
              found    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bzc_pkg::PH_NONE;
      rising_r    <= 1'b1;
      blank_end_r <= '0;
      pre_r       <= 1'b0;
      done_r      <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      rising_r    <= rising_nxt;
      blank_end_r <= blank_end_nxt;
      pre_r       <= pre_nxt;
      done_r      <= done_nxt;
    end
  end

  assign res.crossing_found = found;
  assign res.watched_phase  = phase_nxt;
  assign res.watched_rising = rising_nxt;

  a_arm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.action == bzc_pkg::ACT_ARM |=> !done_r && !pre_r)
    else $error("arm did not clear detection flags");

  a_found_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    found |=> done_r)
    else $error("crossing reported but detector not closed");

  a_found_needs_pre: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> pre_r && !done_r)
    else $error("crossing reported without pre-crossing side");

  a_none_rising: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bzc_pkg::PH_NONE |-> rising_r)
    else $error("invalid phase armed with falling edge");

endmodule
`default_nettype wire
